>>> rtl/dslv_pkg.sv
// shared constants and types for the dual simplex leaving variable pricer
package dslv_pkg;

	// field widths fixed by the row and result words
	localparam int unsigned VAR_W    = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned WEIGHT_W = 32;
	localparam int unsigned DIR_W    = 2;

	// score is a 64 bit quotient, produced two bits per cycle
	localparam int unsigned SCORE_W  = 64;
	localparam int unsigned DIGIT_W  = 2;

	// parameter defaults
	localparam int unsigned VAR_COUNT_DEF  = 65536;
	localparam int unsigned VALUE_BITS_DEF = 32;

	// bound kind codes
	localparam logic [KIND_W-1:0] KIND_LOWER_ONLY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE       = 2'd2;

	// leaving direction codes
	localparam logic [DIR_W-1:0] DIR_NONE     = 2'd0;
	localparam logic [DIR_W-1:0] DIR_TO_LOWER = 2'd1;
	localparam logic [DIR_W-1:0] DIR_TO_UPPER = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

endpackage

>>> rtl/dual_simplex_leaving_variable_pricer_unit.sv
// dual simplex leaving variable pricer: steepest edge score, running best, report on last row
// an eligible row is squared, divided by its weight in the radix-4 restoring divider loop at
//   two quotient bits per step, then compared with the running best and folded in or reported
// rows are taken only in idle, not while one is in the divider or a report waits for the slot;
//   an ineligible row that is not last stays in idle, an ineligible last row goes to the report
// reset: arst_n clears the sequencer, the running best and the result valid flag at once
module dual_simplex_leaving_variable_pricer_unit #(
	parameter int unsigned VAR_COUNT  = dslv_pkg::VAR_COUNT_DEF,
	parameter int unsigned VALUE_BITS = dslv_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// row word
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic        [dslv_pkg::VAR_W-1:0]    basic_var,
	input  logic        [dslv_pkg::KIND_W-1:0]   bound_kind,
	input  logic signed [dslv_pkg::VALUE_W-1:0]  row_value,
	input  logic        [dslv_pkg::WEIGHT_W-1:0] row_weight,
	input  logic                                last_row,

	// result word
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                found,
	output logic        [dslv_pkg::VAR_W-1:0]    leaving_var,
	output logic        [dslv_pkg::DIR_W-1:0]    direction
);

	localparam int unsigned ScoreW  = dslv_pkg::SCORE_W;
	localparam int unsigned WeightW = dslv_pkg::WEIGHT_W;
	localparam int unsigned Steps   = dslv_pkg::SCORE_W / dslv_pkg::DIGIT_W;
	localparam int unsigned CntW    = $clog2(Steps);
	localparam logic [CntW-1:0] CntLast = CntW'(Steps - 1);

	dslv_pkg::state_t state_q;

	// row captured at acceptance
	logic [VALUE_BITS-1:0]           mag_q;
	logic [WeightW-1:0]              weight_q;
	logic [dslv_pkg::VAR_W-1:0]      var_q;
	logic [dslv_pkg::DIR_W-1:0]      dir_q;
	logic                            elig_q;
	logic                            last_q;

	// divider: dividend shifts out the top while quotient bits shift in below
	logic [ScoreW-1:0]               div_q;
	logic [WeightW-1:0]              rem_q;
	logic [CntW-1:0]                 cnt_q;

	// running best
	logic [ScoreW-1:0]               best_score_q;
	logic                            have_best_q;
	logic [dslv_pkg::VAR_W-1:0]      best_var_q;
	logic [dslv_pkg::DIR_W-1:0]      best_dir_q;

	// result register
	logic                            result_valid_q;
	logic                            found_q;
	logic [dslv_pkg::VAR_W-1:0]      leaving_var_q;
	logic [dslv_pkg::DIR_W-1:0]      direction_q;

	// row decode
	logic [VALUE_BITS-1:0]           raw;
	logic                            negative;
	logic                            in_range;
	logic                            eligible;
	logic                            accept;

	assign raw      = row_value[VALUE_BITS-1:0];
	assign negative = raw[VALUE_BITS-1];
	assign in_range = {16'd0, basic_var} < 32'(VAR_COUNT);
	assign accept   = item_valid && item_ready;

	always_comb begin
		eligible = in_range;
		if (bound_kind == dslv_pkg::KIND_FREE) begin
			eligible = 1'b0;
		end
		if (bound_kind == dslv_pkg::KIND_LOWER_ONLY && (negative || raw == '0)) begin
			eligible = 1'b0;
		end
	end

	// square of the magnitude, registered into the dividend
	logic [2*VALUE_BITS-1:0]         sq;
	assign sq = mag_q * mag_q;

	// two restoring steps per cycle
	logic [WeightW:0] trial1, trial2, diff1, diff2, part1;
	logic             ge1, ge2;

	always_comb begin
		trial1 = {rem_q, div_q[ScoreW-1]};
		diff1  = trial1 - {1'b0, weight_q};
		ge1    = trial1 >= {1'b0, weight_q};
		part1  = ge1 ? diff1 : trial1;
		trial2 = {part1[WeightW-1:0], div_q[ScoreW-2]};
		diff2  = trial2 - {1'b0, weight_q};
		ge2    = trial2 >= {1'b0, weight_q};
	end

	// update and report
	logic                            take;
	logic                            new_have;
	logic [dslv_pkg::VAR_W-1:0]      new_var;
	logic [dslv_pkg::DIR_W-1:0]      new_dir;
	logic                            slot_free;
	logic                            report;

	assign take      = elig_q && (!have_best_q || div_q > best_score_q);
	assign new_have  = have_best_q || take;
	assign new_var   = take ? var_q : best_var_q;
	assign new_dir   = take ? dir_q : best_dir_q;
	assign slot_free = !result_valid_q || result_ready;
	// a last row is being reported this cycle
	assign report    = state_q == dslv_pkg::ST_UPD && last_q && slot_free;

	assign item_ready = state_q == dslv_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= dslv_pkg::ST_IDLE;
			cnt_q          <= '0;
			best_score_q   <= '0;
			have_best_q    <= 1'b0;
			best_var_q     <= '0;
			best_dir_q     <= dslv_pkg::DIR_NONE;
			result_valid_q <= 1'b0;
		end else begin
			// a word taken now is cleared unless the next one replaces it
			if (result_valid_q && result_ready && !report) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				dslv_pkg::ST_IDLE: begin
					if (accept) begin
						if (eligible) begin
							state_q <= dslv_pkg::ST_MUL;
						end else if (last_row) begin
							state_q <= dslv_pkg::ST_UPD;
						end
					end
				end
				dslv_pkg::ST_MUL: begin
					cnt_q   <= '0;
					state_q <= dslv_pkg::ST_DIV;
				end
				dslv_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntLast) begin
						state_q <= dslv_pkg::ST_UPD;
					end
				end
				dslv_pkg::ST_UPD: begin
					if (!last_q) begin
						// fold this row into the running best
						if (take) begin
							best_score_q <= div_q;
							have_best_q  <= 1'b1;
							best_var_q   <= var_q;
							best_dir_q   <= dir_q;
						end
						state_q <= dslv_pkg::ST_IDLE;
					end else if (slot_free) begin
						// report and clear for the next pass
						result_valid_q <= 1'b1;
						best_score_q   <= '0;
						have_best_q    <= 1'b0;
						best_var_q     <= '0;
						best_dir_q     <= dslv_pkg::DIR_NONE;
						state_q        <= dslv_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= dslv_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q    <= negative ? (~raw + 1'b1) : raw;
			weight_q <= row_weight;
			var_q    <= basic_var;
			dir_q    <= negative ? dslv_pkg::DIR_TO_UPPER : dslv_pkg::DIR_TO_LOWER;
			elig_q   <= eligible;
			last_q   <= last_row;
		end
		if (state_q == dslv_pkg::ST_MUL) begin
			div_q <= ScoreW'(sq);
			rem_q <= '0;
		end
		if (state_q == dslv_pkg::ST_DIV) begin
			div_q <= {div_q[ScoreW-3:0], ge1, ge2};
			rem_q <= ge2 ? diff2[WeightW-1:0] : trial2[WeightW-1:0];
		end
		if (report) begin
			found_q       <= new_have;
			leaving_var_q <= new_have ? new_var : '0;
			direction_q   <= new_have ? new_dir : dslv_pkg::DIR_NONE;
		end
	end

	assign result_valid = result_valid_q;
	assign found        = found_q;
	assign leaving_var  = leaving_var_q;
	assign direction    = direction_q;

endmodule
